// ----- rtl/tabms_pkg.sv -----
// ----------------------------------------------------------------------------
// tabms_pkg
// Shared types, register codes and helpers of the three-axis smoother.
// ----------------------------------------------------------------------------
package tabms_pkg;

    localparam int XW       = 32;          // sample and coefficient width
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 32;
    localparam int WLEN_W   = 5;
    localparam int BQW_W    = 2;           // biquad warm-up counter
    localparam int MNW_W    = 4;           // mean warm-up counter
    localparam int BQ_ACC_W = 2 * XW + 3;  // five full products, exact
    localparam int BQ_TAPS  = 5;

    typedef logic signed [XW-1:0] t_sample;

    typedef struct packed {
        logic    restart;
        t_sample x_in;
        t_sample y_in;
        t_sample z_in;
    } t_in;

    typedef struct packed {
        t_sample x_out;
        t_sample y_out;
        t_sample z_out;
    } t_out;

    typedef enum logic [1:0] {
        MODE_BIQUAD = 2'd0,
        MODE_MEAN   = 2'd1,
        MODE_BOTH   = 2'd2,
        MODE_ZERO   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IW-1:0] {
        CFG_MODE   = 3'd0,
        CFG_UNWRAP = 3'd1,
        CFG_WLEN   = 3'd2,
        CFG_B0     = 3'd3,
        CFG_B1     = 3'd4,
        CFG_B2     = 3'd5,
        CFG_A1     = 3'd6,
        CFG_A2     = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BQ_RD,
        ST_BQ_PREP,
        ST_BQ_MUL,
        ST_BQ_FIN,
        ST_MN_RD,
        ST_MN_SUM,
        ST_MN_DIV,
        ST_MN_FIN,
        ST_NEXT,
        ST_OUT
    } t_state;

    localparam logic [WLEN_W-1:0] WLEN_RST = 5'd10;
    localparam t_sample B0_RST = 32'sd166590;
    localparam t_sample B1_RST = 32'sd333180;
    localparam t_sample B2_RST = 32'sd166590;
    localparam t_sample A1_RST = -32'sd2109329048;
    localparam t_sample A2_RST = 32'sd1036253583;

    localparam logic [MNW_W-1:0] MNW_MAX = 4'd15;
    localparam logic [BQW_W-1:0] BQW_DONE = 2'd2;

    // pi and 2*pi in Q16.16
    localparam logic signed [XW:0]   ANGLE_PI     = 33'sd205887;
    localparam logic signed [XW+1:0] ANGLE_TWO_PI = 34'sd411775;

    // shift a sample by 2*pi toward its history value
    function automatic logic signed [XW+1:0] unwrap(input t_sample x, input t_sample hist);
        logic signed [XW:0]   d;
        logic signed [XW+1:0] xe;
        begin
            d  = {x[XW-1], x} - {hist[XW-1], hist};
            xe = {{2{x[XW-1]}}, x};
            if (d > ANGLE_PI) begin
                unwrap = xe - ANGLE_TWO_PI;
            end else if (d < -ANGLE_PI) begin
                unwrap = xe + ANGLE_TWO_PI;
            end else begin
                unwrap = xe;
            end
        end
    endfunction

endpackage

// ----- rtl/tabms_div.sv -----
// ----------------------------------------------------------------------------
// tabms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tabms_div #(
    parameter int DW = 38,
    parameter int NW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_rem;
    logic [NW-1:0]    r_den;
    logic [DW-1:0]    r_quo;
    logic [NW:0]      rem_sh;
    logic [NW:0]      rem_sub;
    logic             ge;

    assign rem_sh  = {r_rem, r_quo[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/three_axis_biquad_mean_smoother.sv -----
// ----------------------------------------------------------------------------
// three_axis_biquad_mean_smoother
// Biquad lowpass and window mean on three Q16.16 axes, history in memories.
// ----------------------------------------------------------------------------
//  channel | signals                          | dir | transaction when
//  input   | i_in_valid, o_in_ready, i_in_data | in  | valid & ready at clk
//  output  | o_out_valid, i_out_ready, o_out_data | out | valid & ready at clk
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data  | in  | we high at clk
//
//  One item at a time; the three axes run in turn through one sequencer.
//  Per axis: the biquad runs its five taps through the shared 32x32
//  multiplier, skipped in warm-up; the window mean reads the ring port one
//  slot a cycle, then runs the bit-serial divider. Zero mode goes straight
//  to the output and restart gives no result. A waiting result sits in the
//  output register while the next item is taken.
//  Reset (i_rst_n low, synchronous) and restart clear history at once
//  through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module three_axis_biquad_mean_smoother #(
    parameter int MAX_WINDOW     = 16,
    parameter int SAMPLE_WIDTH   = 32,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  tabms_pkg::t_in            i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tabms_pkg::t_out           o_out_data,
    input  logic                      i_cfg_we,
    input  logic [tabms_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [tabms_pkg::CFG_DW-1:0] i_cfg_data
);

    import tabms_pkg::*;

    localparam int RS     = MAX_WINDOW - 1;              // ring slots per axis
    localparam int RING_N = 3 * RS;
    localparam int RA_W   = $clog2(RING_N);
    localparam int PW     = $clog2(MAX_WINDOW);          // slot index / count
    localparam int NW     = $clog2(MAX_WINDOW + 1);      // window length
    localparam int SUM_W  = XW + 2 + $clog2(MAX_WINDOW); // mean sum, signed
    localparam int SAT_W  = (SAMPLE_WIDTH > 32) ? 32 : SAMPLE_WIDTH;
    localparam logic signed [BQ_ACC_W-1:0] SAT_HI =
        BQ_ACC_W'((BQ_ACC_W'(1) << (SAT_W - 1)) - 1);
    localparam logic signed [BQ_ACC_W-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [BQ_ACC_W-1:0] BQ_HALF =
        BQ_ACC_W'(1) << (COEF_FRAC_BITS - 1);

    function automatic t_sample sat(input logic signed [BQ_ACC_W-1:0] v);
        begin
            if (v > SAT_HI) begin
                sat = SAT_HI[XW-1:0];
            end else if (v < SAT_LO) begin
                sat = SAT_LO[XW-1:0];
            end else begin
                sat = v[XW-1:0];
            end
        end
    endfunction

    // configuration
    t_mode             r_mode;
    logic              r_unwrap;
    logic [WLEN_W-1:0] r_wlen;
    t_sample           r_b0, r_b1, r_b2, r_a1, r_a2;

    // control
    t_state            r_state, n_state;
    logic [1:0]        r_axis;
    logic [BQW_W-1:0]  r_bqw;
    logic [MNW_W-1:0]  r_mnw;
    logic [PW-1:0]     r_pos;
    logic [2:0]        r_mcnt;
    logic [PW-1:0]     r_cnt;
    logic              r_out_valid;

    // per-item window setup
    logic [NW-1:0]     r_n;
    logic [PW-1:0]     r_slots;
    logic [PW-1:0]     r_pose;
    logic [PW-1:0]     r_last;
    logic              r_bq_warm;
    logic              r_mn_warm;

    // datapath
    t_in               r_in;
    t_sample           r_val;
    t_sample           r_xeff;
    t_sample           r_lastv;
    t_sample           r_res [3];
    t_out              r_out;
    logic signed [2*XW-1:0]     r_prod;
    logic                       r_prod_sub;
    logic signed [BQ_ACC_W-1:0] r_acc;
    logic signed [SUM_W-1:0]    r_sum;
    logic                       r_neg;

    // biquad history: one row per axis {y2, y1, x2, x1}
    logic [4*XW-1:0]   bq_mem [3];
    logic [2:0]        r_bq_vld;
    logic [4*XW-1:0]   r_bq_q;
    logic              r_bq_vq;

    // mean ring: RS slots per axis
    logic [XW-1:0]     ring_mem [RING_N];
    logic [RING_N-1:0] r_ring_vld;
    logic [XW-1:0]     r_ring_q;
    logic              r_ring_vq;

    // memory and handshake controls
    logic              bq_rd_en, bq_we;
    logic [4*XW-1:0]   bq_wdata;
    logic              ring_rd_en, ring_we;
    logic [RA_W-1:0]   ring_base, ring_raddr, ring_waddr;
    logic              div_start, div_done;
    logic [SUM_W-1:0]  div_num, div_quo;

    logic              in_acc;
    logic              out_load;

    // window setup from registers
    logic [NW-1:0]     n_c;
    logic [PW-1:0]     slots_c, pose_c, last_c;
    logic              mn_warm_c, bq_warm_c;

    // biquad taps
    logic [4*XW-1:0]   bq_row;
    t_sample           bx1, bx2, by1, by2;
    t_sample           mul_a, mul_b;
    t_sample           xeff_c, ybq;
    logic signed [BQ_ACC_W-1:0] bq_shift;

    // mean
    t_sample                 ring_val;
    logic signed [XW+1:0]    vu;
    logic signed [SUM_W-1:0] s_c;
    logic signed [SUM_W-1:0] yq;
    t_sample                 ymn;
    t_sample                 next_x;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // ---------------- window setup ----------------
    always_comb begin
        if (r_wlen < WLEN_W'(2)) begin
            n_c = NW'(2);
        end else if (int'(r_wlen) > MAX_WINDOW) begin
            n_c = NW'(MAX_WINDOW);
        end else begin
            n_c = NW'(r_wlen);
        end
        slots_c   = PW'(n_c - 1'b1);
        pose_c    = (r_pos >= slots_c) ? '0 : r_pos;
        last_c    = (pose_c == '0) ? PW'(slots_c - 1'b1) : PW'(pose_c - 1'b1);
        mn_warm_c = int'(r_mnw) < int'(slots_c);
        bq_warm_c = r_bqw < BQW_DONE;
    end

    // ---------------- biquad datapath ----------------
    assign bq_row = r_bq_vq ? r_bq_q : '0;
    assign bx1    = bq_row[XW-1:0];
    assign bx2    = bq_row[2*XW-1:XW];
    assign by1    = bq_row[3*XW-1:2*XW];
    assign by2    = bq_row[4*XW-1:3*XW];

    assign xeff_c = (!r_bq_warm && r_unwrap)
                  ? sat(BQ_ACC_W'(unwrap(r_val, bx1))) : r_val;

    always_comb begin
        case (r_mcnt)
            3'd0:    begin mul_a = r_b0; mul_b = r_xeff; end
            3'd1:    begin mul_a = r_b1; mul_b = bx1;    end
            3'd2:    begin mul_a = r_b2; mul_b = bx2;    end
            3'd3:    begin mul_a = r_a1; mul_b = by1;    end
            default: begin mul_a = r_a2; mul_b = by2;    end
        endcase
    end

    assign bq_shift = r_acc >>> COEF_FRAC_BITS;
    assign ybq      = r_bq_warm ? r_xeff : sat(bq_shift);
    assign bq_wdata = {by1, ybq, bx1, r_xeff};

    // ---------------- mean datapath ----------------
    assign ring_val = r_ring_vq ? r_ring_q : '0;
    assign vu       = r_unwrap ? unwrap(r_val, r_lastv) : (XW+2)'(r_val);
    assign s_c      = SUM_W'(vu) + r_sum;
    assign div_num  = s_c[SUM_W-1] ? SUM_W'(-s_c) : SUM_W'(s_c);
    assign yq       = r_neg ? -$signed(div_quo) : $signed(div_quo);
    assign ymn      = r_mn_warm ? r_val : sat(BQ_ACC_W'(yq));

    always_comb begin
        case (r_axis)
            2'd0:    ring_base = '0;
            2'd1:    ring_base = RA_W'(RS);
            default: ring_base = RA_W'(2 * RS);
        endcase
        case (r_axis)
            2'd0:    next_x = r_in.y_in;
            default: next_x = r_in.z_in;
        endcase
    end

    tabms_div #(
        .DW (SUM_W),
        .NW (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_n),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && !i_in_data.restart) begin
                    unique case (r_mode)
                        MODE_ZERO: n_state = ST_OUT;
                        MODE_MEAN: n_state = mn_warm_c ? ST_MN_FIN : ST_MN_RD;
                        default:   n_state = ST_BQ_RD;
                    endcase
                end
            end
            ST_BQ_RD:   n_state = ST_BQ_PREP;
            ST_BQ_PREP: n_state = r_bq_warm ? ST_BQ_FIN : ST_BQ_MUL;
            ST_BQ_MUL:  if (r_mcnt == 3'(BQ_TAPS)) n_state = ST_BQ_FIN;
            ST_BQ_FIN: begin
                if (r_mode == MODE_BOTH) begin
                    n_state = r_mn_warm ? ST_MN_FIN : ST_MN_RD;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_MN_RD:   if (r_cnt == r_slots) n_state = ST_MN_SUM;
            ST_MN_SUM:  n_state = ST_MN_DIV;
            ST_MN_DIV:  if (div_done) n_state = ST_MN_FIN;
            ST_MN_FIN:  n_state = ST_NEXT;
            ST_NEXT: begin
                if (r_axis == 2'd2) begin
                    n_state = ST_OUT;
                end else if (r_mode == MODE_MEAN) begin
                    n_state = r_mn_warm ? ST_MN_FIN : ST_MN_RD;
                end else begin
                    n_state = ST_BQ_RD;
                end
            end
            ST_OUT:     if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        bq_rd_en   = (r_state == ST_BQ_RD);
        bq_we      = (r_state == ST_BQ_FIN);
        ring_rd_en = (r_state == ST_MN_RD) && (r_cnt < r_slots);
        ring_raddr = ring_base + RA_W'(r_cnt);
        ring_we    = (r_state == ST_MN_FIN);
        ring_waddr = ring_base + RA_W'(r_pose);
        div_start  = (r_state == ST_MN_SUM);
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_BIQUAD;
            r_unwrap    <= 1'b0;
            r_wlen      <= WLEN_RST;
            r_b0        <= B0_RST;
            r_b1        <= B1_RST;
            r_b2        <= B2_RST;
            r_a1        <= A1_RST;
            r_a2        <= A2_RST;
            r_bqw       <= '0;
            r_mnw       <= '0;
            r_pos       <= '0;
            r_axis      <= '0;
            r_mcnt      <= '0;
            r_cnt       <= '0;
            r_bq_vld    <= '0;
            r_ring_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                    CFG_UNWRAP: r_unwrap <= i_cfg_data[0];
                    CFG_WLEN:   r_wlen   <= i_cfg_data[WLEN_W-1:0];
                    CFG_B0:     r_b0     <= i_cfg_data;
                    CFG_B1:     r_b1     <= i_cfg_data;
                    CFG_B2:     r_b2     <= i_cfg_data;
                    CFG_A1:     r_a1     <= i_cfg_data;
                    CFG_A2:     r_a2     <= i_cfg_data;
                    default:    ;
                endcase
            end

            // restart drops all history at once
            if (in_acc && i_in_data.restart) begin
                r_bqw      <= '0;
                r_mnw      <= '0;
                r_pos      <= '0;
                r_bq_vld   <= '0;
                r_ring_vld <= '0;
            end
            if (in_acc) begin
                r_axis <= '0;
            end

            r_mcnt <= (r_state == ST_BQ_MUL) ? r_mcnt + 3'd1 : 3'd0;
            r_cnt  <= (r_state == ST_MN_RD) ? PW'(r_cnt + 1'b1) : '0;

            if (bq_we) begin
                r_bq_vld[r_axis] <= 1'b1;
            end
            if (ring_we) begin
                r_ring_vld[ring_waddr] <= 1'b1;
            end

            if (r_state == ST_NEXT) begin
                if (r_axis == 2'd2) begin
                    // end of item: advance warm-up and ring position
                    if (r_mode != MODE_MEAN && r_bq_warm) begin
                        r_bqw <= r_bqw + 1'b1;
                    end
                    if (r_mode != MODE_BIQUAD) begin
                        if (r_mn_warm && r_mnw < MNW_MAX) begin
                            r_mnw <= r_mnw + 1'b1;
                        end
                        r_pos <= (PW'(r_pose + 1'b1) == r_slots) ? '0
                                                                 : PW'(r_pose + 1'b1);
                    end
                end else begin
                    r_axis <= r_axis + 2'd1;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in      <= i_in_data;
            r_val     <= i_in_data.x_in;
            r_n       <= n_c;
            r_slots   <= slots_c;
            r_pose    <= pose_c;
            r_last    <= last_c;
            r_bq_warm <= bq_warm_c;
            r_mn_warm <= mn_warm_c;
            if (r_mode == MODE_ZERO) begin
                r_res[0] <= '0;
                r_res[1] <= '0;
                r_res[2] <= '0;
            end
        end

        if (r_state == ST_BQ_PREP) begin
            r_xeff <= xeff_c;
        end

        // one product per cycle, accumulated the cycle after
        r_prod     <= mul_a * mul_b;
        r_prod_sub <= (r_mcnt >= 3'd3);
        if (r_state == ST_BQ_MUL) begin
            if (r_mcnt == 3'd0) begin
                r_acc <= BQ_HALF;
            end else if (r_prod_sub) begin
                r_acc <= r_acc - BQ_ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + BQ_ACC_W'(r_prod);
            end
        end

        if (r_state == ST_BQ_FIN) begin
            r_val <= ybq;
        end

        if (r_state == ST_MN_RD) begin
            if (r_cnt == '0) begin
                r_sum <= '0;
            end else begin
                r_sum <= r_sum + SUM_W'(ring_val);
                if (PW'(r_cnt - 1'b1) == r_last) begin
                    r_lastv <= ring_val;
                end
            end
        end

        if (r_state == ST_MN_SUM) begin
            r_neg <= s_c[SUM_W-1];
        end

        if (r_state == ST_MN_FIN) begin
            r_val <= ymn;
        end

        if (r_state == ST_NEXT) begin
            r_res[r_axis] <= r_val;
            r_val         <= next_x;
        end

        if (out_load) begin
            r_out.x_out <= r_res[0];
            r_out.y_out <= r_res[1];
            r_out.z_out <= r_res[2];
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (bq_we) begin
            bq_mem[r_axis] <= bq_wdata;
        end
        if (bq_rd_en) begin
            r_bq_q  <= bq_mem[r_axis];
            r_bq_vq <= r_bq_vld[r_axis];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ymn;
        end
        if (ring_rd_en) begin
            r_ring_q  <= ring_mem[ring_raddr];
            r_ring_vq <= r_ring_vld[ring_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/tabms_chk.sv -----
// ----------------------------------------------------------------------------
// tabms_chk
// Port-level checks on the three-axis smoother, bound to the top level.
// ----------------------------------------------------------------------------
module tabms_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input tabms_pkg::t_in               i_in_data,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input tabms_pkg::t_out              o_out_data,
    input logic                         i_cfg_we,
    input logic [tabms_pkg::CFG_IW-1:0] i_cfg_idx,
    input logic [tabms_pkg::CFG_DW-1:0] i_cfg_data
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // a result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // restart transaction yields no result
    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.restart && !o_out_valid |=> !o_out_valid)
        else $error("result after restart");

    // one item in flight: busy after a sample transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in_data.restart |=> !o_in_ready)
        else $error("input taken while busy");

endmodule

bind three_axis_biquad_mean_smoother tabms_chk u_tabms_chk (.*);
